>>> rtl/vgrt_pkg.sv
// Shared types and constants of the voxel grid ray traversal block.
// Used by every module in rtl; depends on nothing.
package vgrt_pkg;

    localparam int CHUNK_SIDE_DEF    = 16;
    localparam int WINDOW_CHUNKS_DEF = 4;
    localparam int TYPE_BITS_DEF     = 8;

    localparam int BASE_W  = 12;
    localparam int VOX_W   = 16;
    localparam int POS_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int DIR_W   = 16;
    localparam int DIST_W  = 31;
    localparam int FACE_W  = 3;
    localparam int HTYPE_W = 8;
    localparam int BTYPE_W = 8;
    localparam int LEN2_W  = 32;
    localparam int LEN_W   = 24;
    localparam int BND_W   = 17;
    localparam int PROD_W  = BND_W + LEN_W;
    localparam int NUM_W   = PROD_W - 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [FACE_W-1:0] FACE_NONE  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd6;

    typedef struct packed {
        logic                     cmd;
        logic signed [VOX_W-1:0]  vox_x;
        logic signed [VOX_W-1:0]  vox_y;
        logic signed [VOX_W-1:0]  vox_z;
        logic [BTYPE_W-1:0]       block_type;
        logic signed [POS_W-1:0]  origin_x;
        logic signed [POS_W-1:0]  origin_y;
        logic signed [POS_W-1:0]  origin_z;
        logic signed [DIR_W-1:0]  dir_x;
        logic signed [DIR_W-1:0]  dir_y;
        logic signed [DIR_W-1:0]  dir_z;
        logic [DIST_W-1:0]        max_dist;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [VOX_W-1:0]  hit_x;
        logic signed [VOX_W-1:0]  hit_y;
        logic signed [VOX_W-1:0]  hit_z;
        logic [HTYPE_W-1:0]       hit_type;
        logic [FACE_W-1:0]        face;
        logic [DIST_W-1:0]        distance;
    } rsp_t;

    typedef struct packed {
        logic       clr_en;
        logic       load;
        logic       mem_wr;
        logic       square;
        logic       sqrt_start;
        logic       set_sat;
        logic       mul;
        logic       div_start;
        logic       div_tdel;
        logic       div_store;
        logic [1:0] axis;
        logic       mem_rd;
        logic       advance;
        logic       out_load;
        logic       out_hit;
    } vgrt_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       is_cast;
        logic       dir_zero;
        logic       sqrt_done;
        logic       div_done;
        logic [2:0] axis_zero;
        logic       exit_win;
        logic       hit;
        logic       stop;
    } vgrt_stat_t;

endpackage

>>> rtl/vgrt_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on vgrt_pkg.
module vgrt_sqrt
    import vgrt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LEN2_W-1:0] radicand,
    output logic              done,
    output logic [LEN_W-1:0]  root
);

    localparam int RadW = LEN2_W + 16;
    localparam int RemW = LEN_W + 3;
    localparam int CntW = $clog2(LEN_W);

    logic [RadW-1:0] rad_reg;
    logic [RemW-1:0] rem_reg;
    logic [LEN_W-1:0] root_reg;
    logic [CntW-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;

    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic ge;

    always_comb
    begin
        rem_sh = {rem_reg[RemW-3:0], rad_reg[RadW-1 -: 2]};
        trial  = RemW'({root_reg, 2'b01});
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(LEN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {radicand, 16'h0000};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RadW-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[LEN_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/vgrt_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on vgrt_pkg.
module vgrt_div
    import vgrt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DIR_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CntW = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg;
    logic [DIR_W-1:0] den_reg;
    logic [DIR_W-1:0] rem_reg;
    logic [CntW-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;

    logic [DIR_W:0] rem_sh;
    logic ge;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? DIR_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIR_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

>>> rtl/vgrt_datapath.sv
// Datapath: window registers, voxel store, set-up arithmetic and walk state.
// Depends on vgrt_pkg, vgrt_sqrt and vgrt_div.
module vgrt_datapath
    import vgrt_pkg::*;
#(
    parameter int ChunkSide    = CHUNK_SIDE_DEF,
    parameter int WindowChunks = WINDOW_CHUNKS_DEF,
    parameter int TypeBits     = TYPE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0]    cfg_data,
    input  req_t                 req,
    input  vgrt_cmd_t            cmd,
    output vgrt_stat_t           stat,
    output rsp_t                 rsp
);

    localparam int Side  = ChunkSide * WindowChunks;
    localparam int Depth = Side * Side * Side;
    localparam int AW    = $clog2(Depth);
    localparam int LW    = $clog2(Side);
    localparam int CW    = (13 + LW > 19) ? 13 + LW : 19;

    logic signed [BASE_W-1:0] base_reg [3];
    logic [AW-1:0] clr_cnt_reg;

    logic cast_reg;
    logic signed [DIR_W-1:0] dir_reg [3];
    logic [FRAC_W-1:0] frac_reg [3];
    logic [DIST_W-1:0] maxd_reg;
    logic [TypeBits-1:0] wdata_reg;
    logic signed [CW-1:0] v_reg [3];
    logic [LEN2_W-1:0] sq_reg [3];
    logic [NUM_W-1:0] prod_reg;
    logic [DIST_W-1:0] tmax_reg [3];
    logic [DIST_W-1:0] tdel_reg [3];
    logic [FACE_W-1:0] face_reg;
    logic inwin_reg;
    logic [TypeBits-1:0] rd_data_reg;
    rsp_t rsp_reg;

    logic [TypeBits-1:0] mem [Depth];

    logic signed [VOX_W-1:0] req_vox [3];
    logic signed [POS_W-1:0] req_org [3];
    logic signed [DIR_W-1:0] req_dir [3];
    logic signed [LEN2_W-1:0] dwide [3];
    logic [LEN2_W-1:0] sq [3];
    logic [LEN2_W-1:0] len2;
    logic signed [CW-1:0] lo [3];
    logic signed [CW-1:0] hi [3];
    logic signed [CW-1:0] l [3];
    logic [2:0] dpos;
    logic [2:0] ax_in;
    logic [2:0] ax_exit;
    logic inwin;
    logic [AW-1:0] addr;
    logic [BND_W-1:0] b_sel;
    logic [DIR_W-1:0] ad_sel;
    logic [PROD_W-1:0] prod_full;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] quo;
    logic [DIST_W-1:0] quo_sat;
    logic div_done;
    logic sqrt_done;
    logic [LEN_W-1:0] len;
    logic [1:0] k;
    logic [DIST_W-1:0] tk;
    logic [DIST_W:0] tsum;
    logic [FACE_W-1:0] face_step;

    function automatic logic [1:0] pick_axis(input logic [DIST_W-1:0] t0,
                                             input logic [DIST_W-1:0] t1,
                                             input logic [DIST_W-1:0] t2);
        logic [1:0] r;
        if (t0 < t1)
        begin
            r = (t0 < t2) ? AXIS_X : AXIS_Z;
        end
        else
        begin
            r = (t1 < t2) ? AXIS_Y : AXIS_Z;
        end
        return r;
    endfunction

    always_comb
    begin
        req_vox[0] = req.vox_x;
        req_vox[1] = req.vox_y;
        req_vox[2] = req.vox_z;
        req_org[0] = req.origin_x;
        req_org[1] = req.origin_y;
        req_org[2] = req.origin_z;
        req_dir[0] = req.dir_x;
        req_dir[1] = req.dir_y;
        req_dir[2] = req.dir_z;
        for (int a = 0; a < 3; a++)
        begin
            dwide[a]   = LEN2_W'(dir_reg[a]);
            sq[a]      = dwide[a] * dwide[a];
            lo[a]      = CW'(base_reg[a]) * CW'(ChunkSide);
            hi[a]      = lo[a] + CW'(Side);
            l[a]       = v_reg[a] - lo[a];
            dpos[a]    = dir_reg[a] > 0;
            ax_in[a]   = !l[a][CW-1] && (l[a] < CW'(Side));
            ax_exit[a] = dpos[a] ? (v_reg[a] >= hi[a]) : (v_reg[a] < lo[a]);
        end
        len2  = sq_reg[0] + sq_reg[1] + sq_reg[2];
        inwin = &ax_in;
        addr  = (AW'(l[2][LW-1:0]) * AW'(Side) + AW'(l[1][LW-1:0])) * AW'(Side)
                + AW'(l[0][LW-1:0]);
    end

    always_comb
    begin
        if (dpos[cmd.axis])
        begin
            b_sel = BND_W'(17'h10000) - BND_W'(frac_reg[cmd.axis]);
        end
        else if (frac_reg[cmd.axis] == '0)
        begin
            b_sel = BND_W'(17'h10000);
        end
        else
        begin
            b_sel = BND_W'(frac_reg[cmd.axis]);
        end
        ad_sel    = dir_reg[cmd.axis][DIR_W-1] ? DIR_W'(-dir_reg[cmd.axis])
                                               : DIR_W'(dir_reg[cmd.axis]);
        prod_full = PROD_W'(b_sel) * PROD_W'(len);
        div_num   = cmd.div_tdel ? NUM_W'({len, 8'h00}) : prod_reg;
        quo_sat   = (quo > NUM_W'(DIST_SAT)) ? DIST_SAT : quo[DIST_W-1:0];
    end

    always_comb
    begin
        k    = pick_axis(tmax_reg[0], tmax_reg[1], tmax_reg[2]);
        tk   = tmax_reg[k];
        tsum = {1'b0, tk} + {1'b0, tdel_reg[k]};
        case (k)
            AXIS_X:  face_step = dpos[0] ? FACE_NEG_X : FACE_POS_X;
            AXIS_Y:  face_step = dpos[1] ? FACE_NEG_Y : FACE_POS_Y;
            default: face_step = dpos[2] ? FACE_NEG_Z : FACE_POS_Z;
        endcase
    end

    vgrt_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (len2),
        .done     (sqrt_done),
        .root     (len)
    );

    vgrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (ad_sel),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                base_reg[a] <= '0;
            end
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BASE_X: base_reg[0] <= cfg_data;
                    REG_BASE_Y: base_reg[1] <= cfg_data;
                    REG_BASE_Z: base_reg[2] <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.mem_wr && inwin)
        begin
            mem[addr] <= wdata_reg;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[addr];
            inwin_reg   <= inwin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cast_reg  <= req.cmd;
            maxd_reg  <= req.max_dist;
            wdata_reg <= TypeBits'(req.block_type);
            face_reg  <= FACE_NONE;
            for (int a = 0; a < 3; a++)
            begin
                dir_reg[a]  <= req_dir[a];
                frac_reg[a] <= req_org[a][FRAC_W-1:0];
                v_reg[a]    <= req.cmd ? CW'($signed(req_org[a][POS_W-1:FRAC_W]))
                                       : CW'(req_vox[a]);
            end
        end
        if (cmd.square)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= sq[a];
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[PROD_W-1:8];
        end
        if (cmd.set_sat)
        begin
            tmax_reg[cmd.axis] <= DIST_SAT;
            tdel_reg[cmd.axis] <= DIST_SAT;
        end
        if (cmd.div_store)
        begin
            if (cmd.div_tdel)
            begin
                tdel_reg[cmd.axis] <= quo_sat;
            end
            else
            begin
                tmax_reg[cmd.axis] <= quo_sat;
            end
        end
        if (cmd.advance)
        begin
            v_reg[k]    <= dpos[k] ? v_reg[k] + CW'(1) : v_reg[k] - CW'(1);
            tmax_reg[k] <= (tsum > {1'b0, DIST_SAT}) ? DIST_SAT : tsum[DIST_W-1:0];
            face_reg    <= face_step;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_hit)
            begin
                rsp_reg.hit      <= 1'b1;
                rsp_reg.hit_x    <= v_reg[0][VOX_W-1:0];
                rsp_reg.hit_y    <= v_reg[1][VOX_W-1:0];
                rsp_reg.hit_z    <= v_reg[2][VOX_W-1:0];
                rsp_reg.hit_type <= HTYPE_W'(rd_data_reg);
                rsp_reg.face     <= face_reg;
                rsp_reg.distance <= tk;
            end
            else
            begin
                rsp_reg <= '0;
            end
        end
    end

    always_comb
    begin
        stat.clr_done  = clr_cnt_reg == AW'(Depth - 1);
        stat.is_cast   = cast_reg;
        stat.dir_zero  = (dir_reg[0] == '0) && (dir_reg[1] == '0) && (dir_reg[2] == '0);
        stat.sqrt_done = sqrt_done;
        stat.div_done  = div_done;
        for (int a = 0; a < 3; a++)
        begin
            stat.axis_zero[a] = dir_reg[a] == '0;
        end
        stat.exit_win  = |ax_exit;
        stat.hit       = inwin_reg && (rd_data_reg != '0);
        stat.stop      = (tk > maxd_reg) || (tk == DIST_SAT);
    end

    assign rsp = rsp_reg;

endmodule

>>> rtl/vgrt_ctrl.sv
// Controller: sequences clearing, writes, cast set-up and the voxel walk.
// Depends on vgrt_pkg.
module vgrt_ctrl
    import vgrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  vgrt_stat_t stat,
    output vgrt_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ROOT,
        S_ROOT_WAIT,
        S_AXIS,
        S_TMAX,
        S_TMAX_WAIT,
        S_TDEL,
        S_TDEL_WAIT,
        S_CHECK,
        S_DECIDE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [1:0] axis_reg;
    logic [1:0] axis_next;
    logic hit_reg;
    logic hit_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.axis   = axis_reg;
        state_next = state_reg;
        axis_next  = axis_reg;
        hit_next   = hit_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!stat.is_cast)
                begin
                    cmd.mem_wr = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.dir_zero)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.square = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    axis_next  = AXIS_X;
                    state_next = S_AXIS;
                end
            end
            S_AXIS:
            begin
                if (stat.axis_zero[axis_reg])
                begin
                    cmd.set_sat = 1'b1;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_TMAX;
                end
            end
            S_TMAX:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_TMAX_WAIT;
            end
            S_TMAX_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_TDEL;
                end
            end
            S_TDEL:
            begin
                cmd.div_tdel  = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_TDEL_WAIT;
            end
            S_TDEL_WAIT:
            begin
                cmd.div_tdel = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_AXIS;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.exit_win)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.hit)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.stop)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_hit  = hit_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        rsp_valid_next = (rsp_valid_reg && rsp_stall) || cmd.out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            axis_reg      <= AXIS_X;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(rsp_valid_reg && rsp_stall))
        else $error("result register overwritten while stalled");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");

    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_en |-> !(cmd.mem_wr || cmd.mem_rd || cmd.load))
        else $error("store access during clearing");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_store || cmd.set_sat) |-> (axis_reg != 2'd3))
        else $error("set-up axis out of range");

endmodule

>>> rtl/voxel_grid_ray_traversal.sv
// Top level of the voxel grid ray traversal block.
// Depends on vgrt_pkg, vgrt_ctrl and vgrt_datapath.
//
// Channels: req (req_valid / req_stall, payload req) takes write and cast items;
// rsp (rsp_valid / rsp_stall, payload rsp) returns one result per cast item;
// cfg (cfg_valid / cfg_ready, cfg_index, cfg_data) sets the window base in chunks.
// After reset the store is cleared one entry per cycle, all Side^3 entries
// (262144 at the default size); req_stall stays high until that is done.
// Config writes are taken at any time; cfg_ready is always high.
// A write item passes the dispatch state and is written to the store. A cast
// item squares the direction and takes its length with the square root; then
// for each nonzero direction axis the shared divider runs two divisions,
// each zero axis is set to saturation, and each walk step is one store read.
// A finished result waits in the output register while rsp_stall is high;
// the next item is accepted meanwhile, but a further cast result holds until
// the register is taken.
module voxel_grid_ray_traversal
    import vgrt_pkg::*;
#(
    parameter int ChunkSide    = CHUNK_SIDE_DEF,
    parameter int WindowChunks = WINDOW_CHUNKS_DEF,
    parameter int TypeBits     = TYPE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0]    cfg_data
);

    vgrt_cmd_t  cmd;
    vgrt_stat_t stat;

    vgrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    vgrt_datapath #(
        .ChunkSide    (ChunkSide),
        .WindowChunks (WindowChunks),
        .TypeBits     (TypeBits)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

    assign cfg_ready = 1'b1;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for voxel_grid_ray_traversal: directed and random writes
// and casts, checked against an in-bench traversal predictor.
// Depends on rtl/vgrt_pkg.sv and the voxel_grid_ray_traversal RTL.
module tb;
    import vgrt_pkg::*;

    localparam int  SIDE       = CHUNK_SIDE_DEF * WINDOW_CHUNKS_DEF;
    localparam int  DEPTH      = SIDE * SIDE * SIDE;
    localparam longint unsigned SAT = 64'h7FFF_FFFF;
    localparam int  LIMIT      = 20_000_000;
    localparam int  DRAIN      = 1000;
    localparam bit  CMD_WRITE  = 1'b0;
    localparam bit  CMD_CAST   = 1'b1;

    class voxel_scoreboard;
        byte unsigned store[DEPTH];
        longint       base[3];
        rsp_t         expected_hits[$];
        int           errors;
        int           writes;
        int           casts;
        int           hits;

        function new();
            foreach (store[i]) store[i] = 0;
            base = '{0, 0, 0};
        endfunction

        function automatic longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function automatic bit locate(longint v[3], output int unsigned idx);
            longint l[3];
            for (int a = 0; a < 3; a++)
            begin
                l[a] = v[a] - base[a] * CHUNK_SIDE_DEF;
                if (l[a] < 0 || l[a] >= SIDE) return 0;
            end
            idx = int'((l[2] * SIDE + l[1]) * SIDE + l[0]);
            return 1;
        endfunction

        function automatic int nearest(longint unsigned t[3]);
            if (t[0] < t[1]) return (t[0] < t[2]) ? 0 : 2;
            return (t[1] < t[2]) ? 1 : 2;
        endfunction

        function automatic rsp_t trace(req_t q);
            longint          v[3], d[3], stp[3], org[3];
            longint unsigned tm[3], td[3], len2, len, maxd, b, ad, f, sum;
            int unsigned     idx;
            int              k;
            logic [FACE_W-1:0] fc;
            rsp_t            o;
            o = '0;
            fc = FACE_NONE;
            maxd = q.max_dist;
            d = '{longint'(q.dir_x), longint'(q.dir_y), longint'(q.dir_z)};
            org = '{longint'(q.origin_x), longint'(q.origin_y), longint'(q.origin_z)};
            len2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
            if (len2 == 0) return o;
            len = root(len2 << 16);
            for (int a = 0; a < 3; a++)
            begin
                v[a] = org[a] >>> 16;
                f = org[a] & 64'hFFFF;
                if (d[a] == 0)
                begin
                    stp[a] = 0;
                    tm[a] = SAT;
                    td[a] = SAT;
                end
                else
                begin
                    ad = (d[a] < 0) ? -d[a] : d[a];
                    stp[a] = (d[a] > 0) ? 1 : -1;
                    b = (d[a] > 0) ? 64'h10000 - f : ((f != 0) ? f : 64'h10000);
                    tm[a] = (b * len) / (ad << 8);
                    td[a] = (len << 8) / ad;
                    if (tm[a] > SAT) tm[a] = SAT;
                    if (td[a] > SAT) td[a] = SAT;
                end
            end
            forever
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (stp[a] > 0 ? v[a] >= base[a] * CHUNK_SIDE_DEF + SIDE
                                   : v[a] < base[a] * CHUNK_SIDE_DEF)
                        return o;
                end
                if (locate(v, idx) && store[idx] != 0)
                begin
                    o.hit = 1'b1;
                    o.hit_x = v[0][15:0];
                    o.hit_y = v[1][15:0];
                    o.hit_z = v[2][15:0];
                    o.hit_type = store[idx];
                    o.face = fc;
                    o.distance = tm[nearest(tm)][DIST_W-1:0];
                    return o;
                end
                k = nearest(tm);
                if (tm[k] > maxd || tm[k] >= SAT) return o;
                v[k] += stp[k];
                sum = tm[k] + td[k];
                tm[k] = (sum > SAT) ? SAT : sum;
                case (k)
                    AXIS_X:  fc = (stp[k] > 0) ? FACE_NEG_X : FACE_POS_X;
                    AXIS_Y:  fc = (stp[k] > 0) ? FACE_NEG_Y : FACE_POS_Y;
                    default: fc = (stp[k] > 0) ? FACE_NEG_Z : FACE_POS_Z;
                endcase
            end
        endfunction

        function void set_base(int index, logic [BASE_W-1:0] value);
            if (index < 3) base[index] = longint'(signed'(value));
        endfunction

        function void note_item(req_t q);
            longint      v[3];
            int unsigned idx;
            rsp_t        r;
            if (q.cmd == CMD_WRITE)
            begin
                writes++;
                v = '{longint'(q.vox_x), longint'(q.vox_y), longint'(q.vox_z)};
                if (locate(v, idx)) store[idx] = q.block_type;
            end
            else
            begin
                casts++;
                r = trace(q);
                if (r.hit) hits++;
                expected_hits.push_back(r);
            end
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            errors++;
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_result(rsp_t r);
            rsp_t e;
            if (expected_hits.size() == 0)
            begin
                report("unexpected result", r, 0);
                return;
            end
            e = expected_hits.pop_front();
            if (r.hit !== e.hit) report("hit", r.hit, e.hit);
            if (r.hit_x !== e.hit_x) report("hit_x", r.hit_x, e.hit_x);
            if (r.hit_y !== e.hit_y) report("hit_y", r.hit_y, e.hit_y);
            if (r.hit_z !== e.hit_z) report("hit_z", r.hit_z, e.hit_z);
            if (r.hit_type !== e.hit_type) report("hit_type", r.hit_type, e.hit_type);
            if (r.face !== e.face) report("face", r.face, e.face);
            if (r.distance !== e.distance) report("distance", r.distance, e.distance);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_t                 rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BASE_W-1:0]    cfg_data;

    voxel_scoreboard sb;
    bit              quiet;
    int              cycles;
    longint          targets[$][3];

    voxel_grid_ray_traversal i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("voxel_grid_ray_traversal verification failed");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall) sb.check_result(rsp);
            rsp_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    function automatic longint lo_of(int a);
        return sb.base[a] * CHUNK_SIDE_DEF;
    endfunction

    function automatic req_t noise_item();
        req_t q;
        q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return q;
    endfunction

    function automatic req_t write_item(longint x, longint y, longint z, int t);
        req_t q;
        q = noise_item();
        q.cmd = CMD_WRITE;
        q.vox_x = x[15:0];
        q.vox_y = y[15:0];
        q.vox_z = z[15:0];
        q.block_type = t[7:0];
        return q;
    endfunction

    function automatic req_t cast_item(longint ox, longint oy, longint oz,
                                       int dx, int dy, int dz, longint md);
        req_t q;
        q = noise_item();
        q.cmd = CMD_CAST;
        q.origin_x = ox[31:0];
        q.origin_y = oy[31:0];
        q.origin_z = oz[31:0];
        q.dir_x = dx[15:0];
        q.dir_y = dy[15:0];
        q.dir_z = dz[15:0];
        q.max_dist = md[30:0];
        return q;
    endfunction

    task send(req_t q);
        if (!quiet && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= q;
        do @(posedge clk); while (req_stall);
        sb.note_item(q);
    endtask

    task settle();
        req_valid <= 1'b0;
        while (sb.expected_hits.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task set_window(int bx, int by, int bz);
        int vals[3];
        vals = '{bx, by, bz};
        for (int a = 0; a < 3; a++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= a[CFG_IDX_W-1:0];
            cfg_data <= vals[a][BASE_W-1:0];
            do @(posedge clk); while (!cfg_ready);
            sb.set_base(a, vals[a][BASE_W-1:0]);
        end
        cfg_valid <= 1'b0;
        targets.delete();
    endtask

    function automatic longint window_pos(int a);
        return ((lo_of(a) + $urandom_range(0, SIDE - 1)) << 16) + $urandom_range(0, 65535);
    endfunction

    task random_phase(int n);
        longint org[3], t[3], dl[3], m;
        int     sel, dv[3];
        for (int i = 0; i < n; i++)
        begin
            quiet = (i >= n / 3 && i < n / 2);
            if (i == n / 2) settle();
            sel = $urandom_range(99);
            if (sel < 40)
            begin
                for (int a = 0; a < 3; a++) t[a] = lo_of(a) + $urandom_range(16, 47);
                send(write_item(t[0], t[1], t[2], ($urandom_range(9) == 0) ? 0 :
                                $urandom_range(1, 255)));
                targets.push_back(t);
            end
            else if (sel < 75 && targets.size() != 0)
            begin
                t = targets[$urandom_range(0, targets.size() - 1)];
                m = 0;
                for (int a = 0; a < 3; a++)
                begin
                    org[a] = window_pos(a);
                    dl[a] = (t[a] << 16) + 32768 - org[a];
                    if ((dl[a] < 0 ? -dl[a] : dl[a]) > m) m = (dl[a] < 0 ? -dl[a] : dl[a]);
                end
                for (int a = 0; a < 3; a++)
                    dv[a] = (m == 0) ? 100 :
                            int'(dl[a] * longint'($urandom_range(300, 32767)) / m);
                send(cast_item(org[0], org[1], org[2], dv[0], dv[1], dv[2],
                               ($urandom_range(7) == 0) ? $urandom_range(0, 2000000)
                                                        : 64'h7FFF_FFFF));
            end
            else if (sel < 90)
            begin
                send(cast_item(window_pos(0), window_pos(1), window_pos(2),
                               $signed($urandom_range(0, 65535)) - 32768,
                               ($urandom_range(4) == 0) ? 0 : $urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768, $urandom));
            end
            else
                send(noise_item());
        end
        quiet = 0;
        settle();
    endtask

    initial
    begin
        longint w0, w1, w2;
        sb = new();
        quiet = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE_X;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_window(0, 0, 0);
        w0 = 10 <<< 16;
        send(write_item(0, 0, 0, 255));
        send(write_item(63, 63, 63, 1));
        send(write_item(64, 5, 5, 7));
        send(write_item(-1, 5, 5, 7));
        send(write_item(-32768, 32767, 0, 9));
        send(write_item(20, 10, 10, 3));
        send(write_item(0, 10, 10, 4));
        send(write_item(10, 20, 10, 5));
        send(write_item(10, 0, 10, 6));
        send(write_item(10, 10, 20, 8));
        send(write_item(10, 10, 0, 2));
        send(write_item(10, 10, 0, 0));
        send(cast_item(w0, w0, w0, 0, 0, 0, 64'h7FFF_FFFF));
        send(cast_item(w0 + 100, w0, w0, 32767, 0, 0, 64'h7FFF_FFFF));
        send(cast_item(w0, w0, w0, -32768, 0, 0, 64'h7FFF_FFFF));
        send(cast_item(w0, w0, w0, 0, 12000, 0, 64'h7FFF_FFFF));
        send(cast_item(w0, w0, w0, 0, -12000, 0, 64'h7FFF_FFFF));
        send(cast_item(w0, w0, w0, 0, 0, 1, 64'h7FFF_FFFF));
        send(cast_item(w0, w0, w0, 0, 0, -1, 64'h7FFF_FFFF));
        send(cast_item(w0, w0, w0, 0, 0, -5000, 0));
        send(cast_item(0, 0, 0, 9000, 0, 0, 64'h7FFF_FFFF));
        send(cast_item(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 777, 777, 777,
                       64'h7FFF_FFFF));
        send(cast_item(w0, w0, w0, 20000, -20000, 20000, 64'h7FFF_FFFF));
        send(cast_item(32'h8000_0000, 32'h7FFF_FFFF, w0, 32767, -32768, 32767, 64'h7FFF_FFFF));
        settle();
        random_phase(130);

        set_window(-2048, 2043, 5);
        w0 = -32768;
        w1 = 32688;
        send(write_item(w0, w1 + 63, 80, 200));
        send(cast_item((w0 + 8) <<< 16, (w1 + 63) <<< 16, 80 <<< 16, -32768, 0, 0,
                       64'h7FFF_FFFF));
        random_phase(130);

        set_window(2043, -2048, -1);
        random_phase(130);

        set_window(-7, 100, -2048);
        w2 = -32768;
        send(write_item(-112, 1600, w2, 17));
        send(cast_item(-112 <<< 16, 1600 <<< 16, (w2 + 40) <<< 16, 0, 0, -32768, 64'h7FFF_FFFF));
        random_phase(130);

        $display("covered %0d write items and %0d cast items, %0d of them hits",
                 sb.writes, sb.casts, sb.hits);
        $display("four window settings including both base extremes; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0)
            $display("voxel_grid_ray_traversal verification clean");
        else
            $display("voxel_grid_ray_traversal verification failed");
        $finish;
    end
endmodule
